/* src/sse_pkg.sv */
// shared constants, codes and item types of the scalar to sparse encoder
`timescale 1ns / 1ps
package sse_pkg;

  // defaults of the top-level parameters
  localparam int DEF_MAX_CODE_SIZE = 4096;
  localparam int DEF_MAX_ACTIVE    = 64;

  // field widths
  localparam int SAMPLE_W    = 32;
  localparam int SIZE_W      = 13;
  localparam int ACT_W       = 7;
  localparam int INDEX_W     = 12;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // product and rounded start
  localparam int PROD_W  = 2 * SAMPLE_W;
  localparam int START_W = SAMPLE_W + 1;

  // remainder pipeline: bits of the start consumed per stage
  localparam int MOD_STEP   = 4;
  localparam int MOD_STAGES = (START_W + MOD_STEP - 1) / MOD_STEP;
  localparam int MOD_W      = MOD_STAGES * MOD_STEP;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MIN      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MAX      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_RESOLUTION = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_SIZE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_COUNT   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIODIC_MODE  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_ENABLE    = 3'd6;

  // register reset values
  localparam logic [SAMPLE_W-1:0] RST_RANGE_MIN      = 32'd0;
  localparam logic [SAMPLE_W-1:0] RST_RANGE_MAX      = 32'd6553600;
  localparam logic [SAMPLE_W-1:0] RST_INV_RESOLUTION = 32'd65536;
  localparam logic [SIZE_W-1:0]   RST_CODE_SIZE      = 13'd121;
  localparam logic [ACT_W-1:0]    RST_ACTIVE_COUNT   = 7'd21;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] range_min;
    logic signed [SAMPLE_W-1:0] range_max;
    logic [SAMPLE_W-1:0]        inv_resolution;
    logic [SIZE_W-1:0]          code_size;
    logic [ACT_W-1:0]           active_count;
    logic                       periodic_mode;
    logic                       clip_enable;
  } sse_cfg_t;

  // after range check: offset from range_min, zero when not positive
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SAMPLE_W-1:0] diff;
  } sse_front_t;

  // rounded start, zero padded on top, and the running remainder
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MOD_W-1:0]    value;
    logic [SIZE_W-1:0]   rem;
  } sse_mod_t;

  // one run handed to the emitter
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   start;
    logic [ACT_W-1:0]    act;
  } sse_run_t;

endpackage

/* src/sse_front.sv */
// front stage: nan and range checks, clipping and offset from range_min
`timescale 1ns / 1ps
module sse_front import sse_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       not_a_number,
  input  sse_cfg_t                   cfg,
  output logic                       out_valid,
  output sse_front_t                 out_item,
  input  logic                       out_ready
);

  logic                       valid;
  sse_front_t                 item;
  sse_front_t                 item_next;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W-1:0] hi;
  logic signed [SAMPLE_W-1:0] xc;
  logic signed [SAMPLE_W:0]   d;

  always_comb begin
    lo = cfg.range_min;
    hi = cfg.range_max;
    // low bound first, so an inverted range ends at range_max
    xc = (sample < lo) ? lo : sample;
    xc = (xc > hi) ? hi : xc;
    d  = $signed({xc[SAMPLE_W-1], xc}) - $signed({lo[SAMPLE_W-1], lo});
    item_next.diff = (!d[SAMPLE_W] && (d != '0)) ? d[SAMPLE_W-1:0] : '0;
    if (not_a_number) begin
      item_next.status = ST_EMPTY;
    end else if (cfg.clip_enable && cfg.periodic_mode) begin
      item_next.status = ST_ERROR;
    end else if (!cfg.clip_enable && ((sample < lo) || (sample > hi))) begin
      item_next.status = ST_ERROR;
    end else begin
      item_next.status = ST_OK;
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

/* src/sse_scale.sv */
// scale stages: multiply by the reciprocal resolution, then round half up
`timescale 1ns / 1ps
module sse_scale import sse_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sse_front_t          in_item,
  input  logic [SAMPLE_W-1:0] inv_resolution,
  output logic                out_valid,
  output sse_mod_t            out_item,
  input  logic                out_ready
);

  localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(64'd1 << (SAMPLE_W - 1));

  logic                valid_a;
  logic [STATUS_W-1:0] status_a;
  logic [PROD_W-1:0]   prod_a;
  logic                ready_a;
  logic                valid_b;
  sse_mod_t            item_b;
  logic                ready_b;
  logic [PROD_W:0]     sum;

  assign ready_b  = !valid_b || out_ready;
  assign ready_a  = !valid_a || ready_b;
  assign in_ready = ready_a;

  // Q32.32 product, one 32 by 32 multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (ready_a) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      status_a <= in_item.status;
      prod_a   <= {{SAMPLE_W{1'b0}}, in_item.diff} * {{SAMPLE_W{1'b0}}, inv_resolution};
    end
  end

  assign sum = {1'b0, prod_a} + HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (ready_b) begin
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && valid_a) begin
      item_b.status <= status_a;
      item_b.value  <= {{(MOD_W - START_W){1'b0}}, sum[PROD_W:SAMPLE_W]};
      item_b.rem    <= '0;
    end
  end

  assign out_valid = valid_b;
  assign out_item  = item_b;

endmodule

/* src/sse_mod_stage.sv */
// one stage of the restoring remainder pipeline for start modulo code size
`timescale 1ns / 1ps
module sse_mod_stage import sse_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sse_mod_t          in_item,
  input  logic [SIZE_W-1:0] size,
  output logic              out_valid,
  output sse_mod_t          out_item,
  input  logic              out_ready
);

  localparam int TOP = MOD_W - 1 - STAGE * MOD_STEP;

  logic              valid;
  sse_mod_t          item;
  logic [SIZE_W-1:0] rem_next;

  // msb first, one dividend bit per step
  always_comb begin
    logic [SIZE_W:0] t;
    rem_next = in_item.rem;
    for (int j = 0; j < MOD_STEP; j++) begin
      t = {rem_next, in_item.value[TOP - j]};
      if (t >= {1'b0, size}) begin
        t = t - {1'b0, size};
      end
      rem_next = t[SIZE_W-1:0];
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.status <= in_item.status;
      item.value  <= in_item.value;
      item.rem    <= rem_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

/* src/sse_emit.sv */
// run emitter: one index per cycle into the output register, unless stalled
`timescale 1ns / 1ps
module sse_emit import sse_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                run_valid,
  output logic                run_ready,
  input  sse_run_t            run_item,
  input  logic [SIZE_W-1:0]   size,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [INDEX_W-1:0]  bit_index,
  output logic                last,
  output logic [STATUS_W-1:0] status
);

  logic                busy;
  logic [SIZE_W-1:0]   idx;
  logic [SIZE_W-1:0]   idx_inc;
  logic [ACT_W-1:0]    cnt;
  logic [STATUS_W-1:0] run_status;
  logic                out_load;
  logic                emit;
  logic                is_last;
  logic                valid_q;
  logic [INDEX_W-1:0]  index_q;
  logic                last_q;
  logic [STATUS_W-1:0] status_q;

  assign out_load  = !valid_q || !out_stall;
  assign emit      = busy && out_load;
  assign is_last   = (cnt == ACT_W'(1)) || (run_status != ST_OK);
  assign run_ready = !busy || (emit && is_last);
  assign idx_inc   = idx + SIZE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (run_ready) begin
      busy <= run_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (run_ready && run_valid) begin
      idx        <= run_item.start;
      cnt        <= (run_item.status == ST_OK) ? run_item.act : ACT_W'(1);
      run_status <= run_item.status;
    end else if (emit) begin
      // wrap past the end of the code
      idx <= (idx_inc == size) ? '0 : idx_inc;
      cnt <= cnt - ACT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (out_load) begin
      valid_q <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      index_q  <= (run_status == ST_OK) ? idx[INDEX_W-1:0] : '0;
      last_q   <= is_last;
      status_q <= run_status;
    end
  end

  assign out_valid = valid_q;
  assign bit_index = index_q;
  assign last      = last_q;
  assign status    = status_q;

endmodule

/* src/scalar_to_sparse_encoder.sv */
// top level of the scalar to sparse encoder
`timescale 1ns / 1ps
// Encodes one signed Q16.16 sample into a contiguous run of active bit
// indices of a sparse code, one result item per index, ascending (in
// periodic mode wrapping to 0 past the code end), the final one marked by
// last. A NaN sample gives a single item with status 1, a range or mode
// error a single item with status 2, both with bit_index 0. Results leave
// at one item per cycle while out_stall is low; a good sample gives
// active_count items (after limiting to 1..MAX_ACTIVE and below the code
// size), a NaN or error sample one item. The run emitter, which produces
// one index per cycle, sets that rate. A new sample can be accepted every
// cycle while the pipeline has room. The range stage loads at the accepting
// edge; multiply, rounding, nine remainder stages, emitter load and output
// register follow. Registers are to be written by the user only while no
// item is in flight, not enforced by the block; cfg_ready is always high.
module scalar_to_sparse_encoder import sse_pkg::*; #(
  parameter int MAX_CODE_SIZE = DEF_MAX_CODE_SIZE,
  parameter int MAX_ACTIVE    = DEF_MAX_ACTIVE
) (
  input  logic                       clk,
  input  logic                       rst,
  // input items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       not_a_number,
  // result items
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [INDEX_W-1:0]         bit_index,
  output logic                       last,
  output logic [STATUS_W-1:0]        status,
  // register writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  sse_cfg_t          cfg;
  logic [SIZE_W-1:0] size_eff;
  logic [ACT_W-1:0]  act_eff;
  logic [SIZE_W-1:0] size_less_one;
  logic [SIZE_W-1:0] clamp_start;

  logic              front_ready;
  logic              front_valid;
  sse_front_t        front_item;
  logic              scale_ready;

  logic     [MOD_STAGES:0] mod_valid;
  logic     [MOD_STAGES:0] mod_ready;
  sse_mod_t mod_item [MOD_STAGES+1];

  sse_run_t          run_item;
  logic              run_ready;

  // configuration registers, writes never stall
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_min      <= RST_RANGE_MIN;
      cfg.range_max      <= RST_RANGE_MAX;
      cfg.inv_resolution <= RST_INV_RESOLUTION;
      cfg.code_size      <= RST_CODE_SIZE;
      cfg.active_count   <= RST_ACTIVE_COUNT;
      cfg.periodic_mode  <= 1'b0;
      cfg.clip_enable    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RANGE_MIN:      cfg.range_min      <= cfg_data;
        CFG_RANGE_MAX:      cfg.range_max      <= cfg_data;
        CFG_INV_RESOLUTION: cfg.inv_resolution <= cfg_data;
        CFG_CODE_SIZE:      cfg.code_size      <= cfg_data[SIZE_W-1:0];
        CFG_ACTIVE_COUNT:   cfg.active_count   <= cfg_data[ACT_W-1:0];
        CFG_PERIODIC_MODE:  cfg.periodic_mode  <= cfg_data[0];
        CFG_CLIP_ENABLE:    cfg.clip_enable    <= cfg_data[0];
        default: begin
          // unused index, write ignored
        end
      endcase
    end
  end

  // effective size, run length; user keeps registers static while busy, unchecked
  always_comb begin
    if (cfg.code_size < SIZE_W'(2)) begin
      size_eff = SIZE_W'(2);
    end else if (32'(cfg.code_size) > 32'(MAX_CODE_SIZE)) begin
      size_eff = SIZE_W'(MAX_CODE_SIZE);
    end else begin
      size_eff = cfg.code_size;
    end
    size_less_one = size_eff - SIZE_W'(1);

    if (cfg.active_count == '0) begin
      act_eff = ACT_W'(1);
    end else if (32'(cfg.active_count) > 32'(MAX_ACTIVE)) begin
      act_eff = ACT_W'(MAX_ACTIVE);
    end else begin
      act_eff = cfg.active_count;
    end
    // the run must leave at least one bit inactive
    if ({{(SIZE_W - ACT_W){1'b0}}, act_eff} > size_less_one) begin
      act_eff = size_less_one[ACT_W-1:0];
    end
  end

  // range check, clipping and offset
  sse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (front_ready),
    .sample       (sample),
    .not_a_number (not_a_number),
    .cfg          (cfg),
    .out_valid    (front_valid),
    .out_item     (front_item),
    .out_ready    (scale_ready)
  );

  assign in_stall = !front_ready;

  // multiply and round half up to the run start
  sse_scale u_scale (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (front_valid),
    .in_ready       (scale_ready),
    .in_item        (front_item),
    .inv_resolution (cfg.inv_resolution),
    .out_valid      (mod_valid[0]),
    .out_item       (mod_item[0]),
    .out_ready      (mod_ready[0])
  );

  // start modulo code size, four dividend bits per stage
  for (genvar g = 0; g < MOD_STAGES; g++) begin : g_mod
    sse_mod_stage #(
      .STAGE (g)
    ) u_mod (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (mod_valid[g]),
      .in_ready  (mod_ready[g]),
      .in_item   (mod_item[g]),
      .size      (size_eff),
      .out_valid (mod_valid[g+1]),
      .out_item  (mod_item[g+1]),
      .out_ready (mod_ready[g+1])
    );
  end

  // periodic takes the remainder, otherwise the start is clamped so the run fits
  assign clamp_start = size_eff - {{(SIZE_W - ACT_W){1'b0}}, act_eff};

  always_comb begin
    run_item.status = mod_item[MOD_STAGES].status;
    run_item.act    = act_eff;
    if (cfg.periodic_mode) begin
      run_item.start = mod_item[MOD_STAGES].rem;
    end else if (mod_item[MOD_STAGES].value >
                 {{(MOD_W - SIZE_W){1'b0}}, clamp_start}) begin
      run_item.start = clamp_start;
    end else begin
      run_item.start = mod_item[MOD_STAGES].value[SIZE_W-1:0];
    end
  end

  assign mod_ready[MOD_STAGES] = run_ready;

  // one index per cycle into the output register, unless out_stall holds it
  sse_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .run_valid (mod_valid[MOD_STAGES]),
    .run_ready (run_ready),
    .run_item  (run_item),
    .size      (size_eff),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bit_index (bit_index),
    .last      (last),
    .status    (status)
  );

endmodule

/* src/sse_checker.sv */
// port checker of the scalar to sparse encoder and its bind
`timescale 1ns / 1ps
module sse_checker import sse_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic signed [SAMPLE_W-1:0] sample,
  input logic                       not_a_number,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [INDEX_W-1:0]         bit_index,
  input logic                       last,
  input logic [STATUS_W-1:0]        status,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [CFG_INDEX_W-1:0]     cfg_index,
  input logic [CFG_DATA_W-1:0]      cfg_data
);

  // no result straight after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // empty and error items stand alone with a zero index
  a_single_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> last && (bit_index == '0))
    else $error("status item not single or index not zero");

  // a run continues without a gap and without a status change
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (status == ST_OK) && !last
      |=> out_valid && (status == ST_OK))
    else $error("run broken before last");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall
      |=> out_valid && $stable(bit_index) && $stable(last) && $stable(status))
    else $error("stalled result changed");

endmodule

bind scalar_to_sparse_encoder sse_checker u_sse_checker (.*);

/* bench/tb_scalar_to_sparse_encoder.sv */
// self-checking testbench of the scalar to sparse encoder
`timescale 1ns / 1ps
module tb_scalar_to_sparse_encoder;
  import sse_pkg::*;

  // cycles without any accepted item before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  // settle time after the last expected result
  localparam int TAIL_CYCLES    = 40;

  // one pending input item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       nan;
  } sample_item_t;

  // one expected result item: an active bit of the code or a flag
  typedef struct packed {
    logic [INDEX_W-1:0]  bit_index;
    logic                last;
    logic [STATUS_W-1:0] status;
  } code_bit_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       not_a_number = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [INDEX_W-1:0]         bit_index;
  logic                       last;
  logic [STATUS_W-1:0]        status;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  sample_item_t pending_samples[$];
  code_bit_t    expected_bits[$];
  sse_cfg_t     enc_cfg;

  int  gap_left = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  int  fail_count = 0;
  // set for the final stretch: no gaps, no stalls
  logic quiet = 1'b0;

  scalar_to_sparse_encoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .not_a_number (not_a_number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bit_index    (bit_index),
    .last         (last),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // single flag item for nan, mode error and range error
  function automatic code_bit_t flag_only(input logic [STATUS_W-1:0] st);
    code_bit_t res;
    res.bit_index = '0;
    res.last      = 1'b1;
    res.status    = st;
    return res;
  endfunction

  // works out the run of active bits of one sample and queues it
  function automatic void encode_sample(input logic signed [SAMPLE_W-1:0] smp,
                                        input logic nan);
    longint          x;
    longint          lo;
    longint          hi;
    longint unsigned size;
    longint unsigned act;
    longint unsigned start;
    longint unsigned idx;
    longint unsigned i;
    logic [63:0]     prod;
    code_bit_t       res;
    // nan takes precedence over every other check
    if (nan) begin
      expected_bits.push_back(flag_only(ST_EMPTY));
      return;
    end
    x  = smp;
    lo = $signed(enc_cfg.range_min);
    hi = $signed(enc_cfg.range_max);
    if (enc_cfg.clip_enable) begin
      // clipping makes no sense with wrap-around
      if (enc_cfg.periodic_mode) begin
        expected_bits.push_back(flag_only(ST_ERROR));
        return;
      end
      // upper bound last, so an inverted range yields range_max
      if (x < lo) x = lo;
      if (x > hi) x = hi;
    end else if (x < lo || x > hi) begin
      expected_bits.push_back(flag_only(ST_ERROR));
      return;
    end
    // size and active count forced into their legal ranges
    size = enc_cfg.code_size;
    if (size < 2) size = 2;
    if (size > DEF_MAX_CODE_SIZE) size = DEF_MAX_CODE_SIZE;
    act = enc_cfg.active_count;
    if (act < 1) act = 1;
    if (act > DEF_MAX_ACTIVE) act = DEF_MAX_ACTIVE;
    if (act > size - 1) act = size - 1;
    // q32.32 product rounded half up, negative offset gives start zero
    if (x - lo <= 0) begin
      start = 0;
    end else begin
      prod  = 64'(x - lo) * 64'(enc_cfg.inv_resolution) + 64'h8000_0000;
      start = prod >> 32;
    end
    if (enc_cfg.periodic_mode) begin
      start = start % size;
    end else if (start > size - act) begin
      start = size - act;
    end
    for (i = 0; i < act; i++) begin
      idx = start + i;
      if (idx >= size) idx = idx - size;
      res.bit_index = INDEX_W'(idx);
      res.last      = (i == act - 1);
      res.status    = ST_OK;
      expected_bits.push_back(res);
    end
  endfunction

  // input side: items from the pending queue, random gaps between them
  always @(posedge clk) begin : drive_samples
    sample_item_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      // item taken at this edge: predict its results now
      if (in_valid && !in_stall) encode_sample(sample, not_a_number);
      // a stalled item holds its payload
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 && !quiet) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          next_item = pending_samples.pop_front();
          sample       <= next_item.sample;
          not_a_number <= next_item.nan;
          in_valid     <= 1'b1;
          // occasionally a gap after this item
          if (!quiet && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 19);
          else gap_left <= 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    code_bit_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bits.size() == 0) begin
          $display("%0t unexpected item: index %0d last %0b status %0d",
                   $time, bit_index, last, status);
          fail_count = fail_count + 1;
        end else begin
          want = expected_bits.pop_front();
          if (want.bit_index !== bit_index || want.last !== last ||
              want.status !== status) begin
            $display("%0t mismatch (index/last/status): expected %0d/%0b/%0d, got %0d/%0b/%0d",
                     $time, want.bit_index, want.last, want.status,
                     bit_index, last, status);
            fail_count = fail_count + 1;
          end
        end
      end
      // random stall bursts, none in the quiet stretch
      if (quiet) begin
        out_stall  <= 1'b0;
        stall_left <= 0;
      end else if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 18);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no accepted item on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog expired", $time);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // one register write; cfg_valid stays high for a following write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RANGE_MIN:      enc_cfg.range_min      = data;
      CFG_RANGE_MAX:      enc_cfg.range_max      = data;
      CFG_INV_RESOLUTION: enc_cfg.inv_resolution = data;
      CFG_CODE_SIZE:      enc_cfg.code_size      = data[SIZE_W-1:0];
      CFG_ACTIVE_COUNT:   enc_cfg.active_count   = data[ACT_W-1:0];
      CFG_PERIODIC_MODE:  enc_cfg.periodic_mode  = data[0];
      CFG_CLIP_ENABLE:    enc_cfg.clip_enable    = data[0];
      default: ;
    endcase
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic nan);
    sample_item_t item;
    item.sample = smp;
    item.nan    = nan;
    pending_samples.push_back(item);
  endtask

  // wait until every item is sent and every result has come back
  task automatic drain();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_bits.size() != 0);
  endtask

  // a fresh random setting of all registers, extremes included
  task automatic random_settings();
    int unsigned         pick;
    logic [SAMPLE_W-1:0] rmin;
    logic [SAMPLE_W-1:0] rmax;
    logic [SAMPLE_W-1:0] inv;
    logic [SIZE_W-1:0]   sz;
    logic [ACT_W-1:0]    act;
    logic                per;
    logic                clip;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      // modest range of up to 200.0 around zero
      rmin = $urandom_range(0, 26214400) - 32'd13107200;
      rmax = rmin + $urandom_range(1, 13107200);
    end else if (pick < 8) begin
      rmin = $urandom;
      rmax = $urandom;
    end else if (pick == 8) begin
      rmin = 32'h8000_0000;
      rmax = 32'h7fff_ffff;
    end else begin
      rmin = $urandom;
      rmax = rmin;
    end
    case ($urandom_range(0, 5))
      0, 1, 2, 3: inv = $urandom_range(32'h1000, 32'h8_0000);
      4:          inv = $urandom;
      default:    inv = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
    endcase
    case ($urandom_range(0, 7))
      0:       sz = 13'd4096;
      1:       sz = $urandom_range(0, 8191);
      default: sz = $urandom_range(2, 256);
    endcase
    if ($urandom_range(0, 9) == 0) act = $urandom_range(0, 127);
    else act = $urandom_range(1, 64);
    per  = $urandom_range(0, 1);
    clip = $urandom_range(0, 1);
    // periodic with clipping only errors, keep it uncommon
    if (per && clip && $urandom_range(0, 3) != 0) clip = 1'b0;
    write_reg(CFG_RANGE_MIN, rmin);
    write_reg(CFG_RANGE_MAX, rmax);
    write_reg(CFG_INV_RESOLUTION, inv);
    write_reg(CFG_CODE_SIZE, CFG_DATA_W'(sz));
    write_reg(CFG_ACTIVE_COUNT, CFG_DATA_W'(act));
    write_reg(CFG_PERIODIC_MODE, CFG_DATA_W'(per));
    write_reg(CFG_CLIP_ENABLE, CFG_DATA_W'(clip));
    cfg_valid <= 1'b0;
  endtask

  // mostly in-range samples, some boundaries, noise and nan
  task automatic random_samples(input int count);
    int                  k;
    int unsigned         pick;
    longint              lo;
    longint              hi;
    longint              span;
    logic [SAMPLE_W-1:0] smp;
    logic                nan;
    lo = $signed(enc_cfg.range_min);
    hi = $signed(enc_cfg.range_max);
    for (k = 0; k < count; k++) begin
      nan  = 1'b0;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        nan = 1'b1;
        smp = $urandom;
      end else if (pick <= 2) begin
        smp = $urandom;
      end else if (pick <= 4) begin
        case ($urandom_range(0, 3))
          0:       smp = SAMPLE_W'(lo);
          1:       smp = SAMPLE_W'(hi);
          2:       smp = SAMPLE_W'(lo - 1);
          default: smp = SAMPLE_W'(hi + 1);
        endcase
      end else if (hi >= lo) begin
        span = hi - lo + 1;
        smp  = SAMPLE_W'(lo + longint'({$urandom, $urandom} % span));
      end else begin
        smp = $urandom;
      end
      push_sample(smp, nan);
    end
  endtask

  initial begin : run_test
    int ph;
    // predictor starts from the register reset values
    enc_cfg.range_min      = RST_RANGE_MIN;
    enc_cfg.range_max      = RST_RANGE_MAX;
    enc_cfg.inv_resolution = RST_INV_RESOLUTION;
    enc_cfg.code_size      = RST_CODE_SIZE;
    enc_cfg.active_count   = RST_ACTIVE_COUNT;
    enc_cfg.periodic_mode  = 1'b0;
    enc_cfg.clip_enable    = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset setting: range 0 to 100.0, one bucket per unit
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'h0000_8000, 1'b0);   // exactly half, rounds up
    push_sample(32'h0000_7fff, 1'b0);   // just below half, rounds down
    push_sample(32'h0032_8000, 1'b0);   // 50.5
    push_sample(32'h0064_0000, 1'b0);   // range_max, run just fits at the top of the code
    push_sample(32'h0063_ffff, 1'b0);
    push_sample(32'h0064_0001, 1'b0);   // just above range
    push_sample(32'hffff_ffff, 1'b0);   // just below range
    push_sample(32'h8000_0000, 1'b1);   // nan wins over range error
    push_sample(32'h7fff_ffff, 1'b0);
    drain();

    // clipping to -10.0 .. 10.0
    write_reg(CFG_CLIP_ENABLE, 32'd1);
    write_reg(CFG_RANGE_MIN, 32'hfff6_0000);
    write_reg(CFG_RANGE_MAX, 32'h000a_0000);
    cfg_valid <= 1'b0;
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h7fff_ffff, 1'b0);
    drain();

    // inverted range with clipping: clipped to range_max, start zero
    write_reg(CFG_RANGE_MIN, 32'h0005_0000);
    write_reg(CFG_RANGE_MAX, 32'hfffb_0000);
    cfg_valid <= 1'b0;
    push_sample(32'h0000_0000, 1'b0);
    drain();

    // inverted range without clipping: always an error
    write_reg(CFG_CLIP_ENABLE, 32'd0);
    cfg_valid <= 1'b0;
    push_sample(32'h0000_0000, 1'b0);
    drain();

    // periodic together with clipping is a mode error
    write_reg(CFG_PERIODIC_MODE, 32'd1);
    write_reg(CFG_CLIP_ENABLE, 32'd1);
    cfg_valid <= 1'b0;
    push_sample(32'h0001_0000, 1'b0);
    drain();

    // periodic, size and count below their minimum
    write_reg(CFG_CLIP_ENABLE, 32'd0);
    write_reg(CFG_RANGE_MIN, 32'h0000_0000);
    write_reg(CFG_RANGE_MAX, 32'h0064_0000);
    write_reg(CFG_INV_RESOLUTION, 32'h0001_0000);
    write_reg(CFG_CODE_SIZE, 32'd0);
    write_reg(CFG_ACTIVE_COUNT, 32'd0);
    cfg_valid <= 1'b0;
    push_sample(32'h0001_0000, 1'b0);
    push_sample(32'h0064_0000, 1'b0);
    drain();

    // full range, largest factor, size and count above their maximum
    write_reg(CFG_RANGE_MIN, 32'h8000_0000);
    write_reg(CFG_RANGE_MAX, 32'h7fff_ffff);
    write_reg(CFG_INV_RESOLUTION, 32'hffff_ffff);
    write_reg(CFG_CODE_SIZE, 32'd8191);
    write_reg(CFG_ACTIVE_COUNT, 32'd127);
    cfg_valid <= 1'b0;
    push_sample(32'h7fff_ffff, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    drain();

    // same without wrap: run clamped to the top of the code
    write_reg(CFG_PERIODIC_MODE, 32'd0);
    cfg_valid <= 1'b0;
    push_sample(32'h7fff_ffff, 1'b0);
    push_sample(32'h0000_0001, 1'b0);
    drain();

    // smallest code: active count cut to size minus one
    write_reg(CFG_CODE_SIZE, 32'd2);
    write_reg(CFG_ACTIVE_COUNT, 32'd64);
    cfg_valid <= 1'b0;
    push_sample(32'h7fff_ffff, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    drain();

    // random settings, the last one without gaps or stalls
    for (ph = 0; ph < 8; ph++) begin
      if (ph == 7) quiet = 1'b1;
      random_settings();
      random_samples(50);
      drain();
    end

    // let any stray result show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_bits.size() != 0) begin
      $display("%0t %0d expected items never arrived", $time, expected_bits.size());
      fail_count = fail_count + 1;
    end
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sse_pkg.sv
src/sse_front.sv
src/sse_scale.sv
src/sse_mod_stage.sv
src/sse_emit.sv
src/scalar_to_sparse_encoder.sv
src/sse_checker.sv
bench/tb_scalar_to_sparse_encoder.sv
